### rtl/lz4_style_hunk_decompressor_macros.svh
// Assertion helpers for the checker file lz4h_checker.sv.
`ifndef LZ4_STYLE_HUNK_DECOMPRESSOR_MACROS_SVH
`define LZ4_STYLE_HUNK_DECOMPRESSOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LZ4H_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define LZ4H_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/lz4h_pkg.sv
// ----------------------------------------------------------------------------
// lz4h_pkg
// Shared types, phase codes and helpers for the hunk decompressor.
// ----------------------------------------------------------------------------
package lz4h_pkg;

	localparam int MAX_RESULTS = 16;

	localparam logic [3:0] PH_HEADER   = 4'd0;
	localparam logic [3:0] PH_TOKEN    = 4'd1;
	localparam logic [3:0] PH_LITEXT   = 4'd2;
	localparam logic [3:0] PH_LIT      = 4'd3;
	localparam logic [3:0] PH_DIST0    = 4'd4;
	localparam logic [3:0] PH_DIST1    = 4'd5;
	localparam logic [3:0] PH_MATCHEXT = 4'd6;
	localparam logic [3:0] PH_COPY     = 4'd7;
	localparam logic [3:0] PH_HALT     = 4'd8;

	localparam logic [3:0] NIBBLE_EXT  = 4'hf;
	localparam logic [7:0] BYTE_EXT    = 8'hff;
	localparam logic [31:0] MIN_MATCH  = 32'd4;

	typedef struct packed {
		logic accept;
		logic exec;
		logic load_stat;
		logic bstart;
		logic rd;
		logic wr;
	} dp_cmd_t;

	typedef struct packed {
		logic phase_copy;
		logic burst_more;
	} dp_stat_t;

	function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hffff_ffff : s[31:0];
	endfunction

endpackage

### rtl/lz4h_if.sv
// ----------------------------------------------------------------------------
// lz4h_if
// Valid/ready channels for compressed input beats and result beats.
// ----------------------------------------------------------------------------
interface lz4h_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] in_byte;

	modport source (output valid, cmd, in_byte, input ready);
	modport sink (input valid, cmd, in_byte, output ready);
endinterface

interface lz4h_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       has_byte;
	logic       error_flag;
	logic       copy_pending;
	logic       stream_done;
	logic       last;

	modport source (output valid, out_byte, has_byte, error_flag, copy_pending,
		stream_done, last, input ready);
	modport sink (input valid, out_byte, has_byte, error_flag, copy_pending,
		stream_done, last, output ready);
endinterface

### rtl/lz4h_ram.sv
// ----------------------------------------------------------------------------
// lz4h_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lz4h_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/lz4h_ctrl.sv
// ----------------------------------------------------------------------------
// lz4h_ctrl
// Sequencer: accepts one beat, steps the datapath, emits result beats.
// ----------------------------------------------------------------------------
module lz4h_ctrl
	import lz4h_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	localparam logic [2:0] C_IDLE   = 3'd0;
	localparam logic [2:0] C_EXEC   = 3'd1;
	localparam logic [2:0] C_STAT   = 3'd2;
	localparam logic [2:0] C_BSTART = 3'd3;
	localparam logic [2:0] C_RD     = 3'd4;
	localparam logic [2:0] C_WR     = 3'd5;
	localparam logic [2:0] C_WAIT   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;

	assign in_ready  = (state_q == C_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			C_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = C_EXEC;
				end
			end
			C_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = C_STAT;
			end
			C_STAT: begin
				if (stat.phase_copy) begin
					state_d = C_BSTART;
				end else begin
					cmd.load_stat = 1'b1;
					state_d       = C_WAIT;
				end
			end
			C_BSTART: begin
				cmd.bstart = 1'b1;
				state_d    = C_RD;
			end
			C_RD: begin
				cmd.rd  = 1'b1;
				state_d = C_WR;
			end
			C_WR: begin
				cmd.wr  = 1'b1;
				state_d = C_WAIT;
			end
			C_WAIT: begin
				if (out_valid_q && out_ready) begin
					state_d = stat.burst_more ? C_RD : C_IDLE;
				end
			end
			default: begin
				state_d = C_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= C_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_stat || cmd.wr) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/lz4h_dp.sv
// ----------------------------------------------------------------------------
// lz4h_dp
// Decoder state, history RAM and result register.
// ----------------------------------------------------------------------------
module lz4h_dp
	import lz4h_pkg::*;
#(
	parameter int HISTORY_DEPTH = 65536,
	parameter int BURST         = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_cmd,
	input  logic [7:0]  in_byte,
	input  dp_cmd_t     cmd,
	output dp_stat_t    stat,
	output logic [7:0]  out_byte,
	output logic        has_byte,
	output logic        error_flag,
	output logic        copy_pending,
	output logic        stream_done,
	output logic        last
);

	localparam int AW  = $clog2(HISTORY_DEPTH);
	localparam int CAP = (BURST > MAX_RESULTS) ? MAX_RESULTS : ((BURST < 1) ? 1 : BURST);
	localparam int BW  = $clog2(CAP + 1);

	logic [3:0]    phase_q, n_phase;
	logic [1:0]    hdr_q, n_hdr;
	logic [31:0]   hunk_left_q, n_hunk_left;
	logic [31:0]   prod_q, n_prod;
	logic [31:0]   lit_left_q, n_lit_left;
	logic [3:0]    mnib_q, n_mnib;
	logic [31:0]   match_left_q, n_match_left;
	logic [15:0]   dist_q, n_dist;
	logic [31:0]   consumed_q, n_consumed;
	logic [AW-1:0] wp_q, n_wp;
	logic [31:0]   stream_len_q;
	logic          cmd_q;
	logic [7:0]    byte_q;
	logic          lit_q, n_lit;
	logic [BW-1:0] burst_q;
	logic          fin_pend_q, fin_done_q;

	logic          take;
	logic [15:0]   dist_full;
	logic          ram_we;
	logic [7:0]    ram_wdata, ram_rdata;
	logic [AW-1:0] ram_raddr;
	logic          done_now;

	assign take = !cmd_q && phase_q != PH_COPY && phase_q != PH_HALT &&
		!(phase_q == PH_HEADER && hdr_q == 2'd0 && consumed_q >= stream_len_q);
	assign dist_full = {byte_q, dist_q[7:0]};
	assign done_now  = phase_q == PH_HEADER && hdr_q == 2'd0 && consumed_q >= stream_len_q;

	assign stat.phase_copy = (phase_q == PH_COPY);
	assign stat.burst_more = (burst_q != '0);

	// Step logic for one compressed byte
	always_comb begin
		n_phase      = phase_q;
		n_hdr        = hdr_q;
		n_hunk_left  = hunk_left_q;
		n_prod       = prod_q;
		n_lit_left   = lit_left_q;
		n_mnib       = mnib_q;
		n_match_left = match_left_q;
		n_dist       = dist_q;
		n_consumed   = consumed_q;
		n_wp         = wp_q;
		n_lit        = 1'b0;
		if (take) begin
			n_consumed = sat_add32(consumed_q, 32'd1);
			if (phase_q != PH_HEADER && hunk_left_q != 32'd0) begin
				n_hunk_left = hunk_left_q - 32'd1;
			end
			case (phase_q)
				PH_HEADER: begin
					if (hdr_q == 2'd0) begin
						n_hunk_left = 32'(byte_q);
						n_prod      = 32'd0;
					end else begin
						n_hunk_left = hunk_left_q | (32'(byte_q) << {hdr_q, 3'b000});
					end
					n_hdr = hdr_q + 2'd1;
					if (hdr_q == 2'd3) begin
						n_phase = (n_hunk_left == 32'd0) ? PH_HEADER : PH_TOKEN;
					end
				end
				PH_TOKEN: begin
					n_mnib     = byte_q[3:0];
					n_lit_left = 32'(byte_q[7:4]);
					if (byte_q[7:4] == NIBBLE_EXT) begin
						n_phase = PH_LITEXT;
					end else if (byte_q[7:4] == 4'd0) begin
						n_phase = (n_hunk_left == 32'd0) ? PH_HEADER : PH_DIST0;
						n_hdr   = 2'd0;
					end else begin
						n_phase = PH_LIT;
					end
				end
				PH_LITEXT: begin
					n_lit_left = sat_add32(lit_left_q, 32'(byte_q));
					if (byte_q != BYTE_EXT) begin
						if (n_lit_left == 32'd0) begin
							n_phase = (n_hunk_left == 32'd0) ? PH_HEADER : PH_DIST0;
							n_hdr   = 2'd0;
						end else begin
							n_phase = PH_LIT;
						end
					end
				end
				PH_LIT: begin
					n_lit  = 1'b1;
					n_wp   = wp_q + AW'(1);
					n_prod = sat_add32(prod_q, 32'd1);
					if (lit_left_q != 32'd0) begin
						n_lit_left = lit_left_q - 32'd1;
					end
					if (n_lit_left == 32'd0) begin
						n_phase = (n_hunk_left == 32'd0) ? PH_HEADER : PH_DIST0;
						n_hdr   = 2'd0;
					end
				end
				PH_DIST0: begin
					n_dist  = {8'd0, byte_q};
					n_phase = PH_DIST1;
				end
				PH_DIST1: begin
					n_dist = dist_full;
					if (dist_full == 16'd0 || {16'd0, dist_full} > prod_q) begin
						n_phase = PH_HALT;
					end else if (mnib_q == NIBBLE_EXT) begin
						n_match_left = 32'(NIBBLE_EXT);
						n_phase      = PH_MATCHEXT;
					end else begin
						n_match_left = 32'(mnib_q) + MIN_MATCH;
						n_phase      = PH_COPY;
					end
				end
				PH_MATCHEXT: begin
					n_match_left = sat_add32(match_left_q, 32'(byte_q));
					if (byte_q != BYTE_EXT) begin
						n_match_left = sat_add32(n_match_left, MIN_MATCH);
						n_phase      = PH_COPY;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign ram_we    = (cmd.exec && n_lit) || cmd.wr;
	assign ram_wdata = cmd.wr ? ram_rdata : byte_q;
	assign ram_raddr = wp_q - dist_q[AW-1:0];

	lz4h_ram #(
		.WIDTH (8),
		.DEPTH (HISTORY_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wp_q),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HEADER;
			hdr_q        <= 2'd0;
			hunk_left_q  <= 32'd0;
			prod_q       <= 32'd0;
			lit_left_q   <= 32'd0;
			mnib_q       <= 4'd0;
			match_left_q <= 32'd0;
			dist_q       <= 16'd0;
			consumed_q   <= 32'd0;
			wp_q         <= '0;
			stream_len_q <= 32'd0;
			burst_q      <= '0;
			lit_q        <= 1'b0;
		end else begin
			if (cfg_we) begin
				stream_len_q <= cfg_wdata;
			end
			if (cmd.exec) begin
				phase_q      <= n_phase;
				hdr_q        <= n_hdr;
				hunk_left_q  <= n_hunk_left;
				prod_q       <= n_prod;
				lit_left_q   <= n_lit_left;
				mnib_q       <= n_mnib;
				match_left_q <= n_match_left;
				dist_q       <= n_dist;
				consumed_q   <= n_consumed;
				wp_q         <= n_wp;
				lit_q        <= n_lit;
			end
			if (cmd.bstart) begin
				burst_q <= (match_left_q > 32'(CAP)) ? BW'(CAP) : BW'(match_left_q);
			end
			if (cmd.wr) begin
				wp_q         <= wp_q + AW'(1);
				prod_q       <= sat_add32(prod_q, 32'd1);
				match_left_q <= match_left_q - 32'd1;
				burst_q      <= burst_q - BW'(1);
				if (match_left_q == 32'd1) begin
					phase_q <= (hunk_left_q == 32'd0) ? PH_HEADER : PH_TOKEN;
					hdr_q   <= 2'd0;
				end
			end
		end
	end

	// Payload registers: no reset
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cmd_q  <= in_cmd;
			byte_q <= in_byte;
		end
		if (cmd.bstart) begin
			fin_pend_q <= match_left_q > 32'(CAP);
			fin_done_q <= match_left_q <= 32'(CAP) && hunk_left_q == 32'd0 &&
				consumed_q >= stream_len_q;
		end
		if (cmd.load_stat) begin
			out_byte     <= lit_q ? byte_q : 8'd0;
			has_byte     <= lit_q;
			error_flag   <= (phase_q == PH_HALT);
			copy_pending <= (phase_q == PH_COPY);
			stream_done  <= done_now;
			last         <= 1'b1;
		end else if (cmd.wr) begin
			out_byte     <= ram_rdata;
			has_byte     <= 1'b1;
			error_flag   <= 1'b0;
			copy_pending <= fin_pend_q;
			stream_done  <= fin_done_q;
			last         <= (burst_q == BW'(1));
		end
	end

endmodule

### rtl/lz4_style_hunk_decompressor.sv
// A status or literal result beat is loaded in the status state, after accept and execute.
// Match copies: the first byte goes through execute, status, burst start, RAM read and RAM write;
// each later byte repeats hand-off, RAM read and RAM write; a result stall holds the burst.
// Flow: one beat at a time; the next beat is taken once the last result beat is taken.
// A burst carries at most min(BURST,16) bytes.
// Reset (arst_n low): clears decoder state and stream_length; history RAM is not cleared.
// ----------------------------------------------------------------------------
// lz4_style_hunk_decompressor
// Top level: controller, datapath and history RAM wired to the channels.
// ----------------------------------------------------------------------------
module lz4_style_hunk_decompressor
	import lz4h_pkg::*;
#(
	parameter int HISTORY_DEPTH = 65536,
	parameter int BURST         = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	lz4h_in_if.sink     din,
	lz4h_out_if.source  dout
);

	// Command and status between the sequencer and the datapath
	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Sequencer: one input beat in flight; each result beat waits in the
	// output register until taken before the next step goes on.
	lz4h_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (din.valid),
		.in_ready  (din.ready),
		.out_valid (dout.valid),
		.out_ready (dout.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Datapath: hunk/sequence state, 64K history and the result register.
	lz4h_dp #(
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.BURST         (BURST)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_cmd       (din.cmd),
		.in_byte      (din.in_byte),
		.cmd          (cmd),
		.stat         (stat),
		.out_byte     (dout.out_byte),
		.has_byte     (dout.has_byte),
		.error_flag   (dout.error_flag),
		.copy_pending (dout.copy_pending),
		.stream_done  (dout.stream_done),
		.last         (dout.last)
	);

endmodule

### rtl/lz4h_checker.sv
// ----------------------------------------------------------------------------
// lz4h_checker
// Port-level checks on the decompressor, bound to the top level.
// ----------------------------------------------------------------------------
`include "lz4_style_hunk_decompressor_macros.svh"

module lz4h_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic has_byte,
	input logic error_flag,
	input logic last
);

	`LZ4H_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped")
	`LZ4H_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second beat taken early")
	`LZ4H_ASSERT_IMPL(a_err_nobyte, out_valid && error_flag, !has_byte, "byte after halt")
	`LZ4H_ASSERT_IMPL(a_stat_last, out_valid && !has_byte, last, "status beat not last")

endmodule

bind lz4_style_hunk_decompressor lz4h_checker u_lz4h_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (din.valid),
	.in_ready   (din.ready),
	.out_valid  (dout.valid),
	.out_ready  (dout.ready),
	.has_byte   (dout.has_byte),
	.error_flag (dout.error_flag),
	.last       (dout.last)
);

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of the hunk decompressor: builds LZ4-style hunks, feeds
// them byte by byte with drain beats, and compares every result beat against
// an in-bench decoder.
// ----------------------------------------------------------------------------
module testbench;
	import lz4h_pkg::*;

	localparam int BURST = 16;

	// One expected or observed result beat.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       error_flag;
		logic       copy_pending;
		logic       stream_done;
		logic       last;
	} result_t;

	// Decoder mirror plus the queue of result beats it predicts.
	class hunk_scoreboard;
		logic [3:0]  ph;
		logic [1:0]  hdr_cnt;
		logic [31:0] budget, produced, lit_left, match_left, consumed, stream_len;
		logic [3:0]  mnib;
		logic [15:0] back_dist, wptr;
		logic [7:0]  hist [65536];
		logic [7:0]  step_bytes[$];
		result_t     expected_q[$];
		int          mismatches, results_seen, bytes_seen, bursts;

		function new();
			ph = PH_HEADER; hdr_cnt = 0; budget = 0; produced = 0; lit_left = 0;
			match_left = 0; consumed = 0; stream_len = 0; mnib = 0; back_dist = 0; wptr = 0;
			mismatches = 0; results_seen = 0; bytes_seen = 0; bursts = 0;
		endfunction

		function logic [31:0] clamp_inc(logic [31:0] a, logic [31:0] b);
			logic [32:0] s;
			s = {1'b0, a} + {1'b0, b};
			if (s[32])
				return '1;
			return s[31:0];
		endfunction

		function void emit(logic [7:0] b);
			hist[wptr] = b;
			wptr = wptr + 16'd1;
			produced = clamp_inc(produced, 1);
			step_bytes.push_back(b);
		endfunction

		function void end_literals();
			if (budget == 0) begin
				ph = PH_HEADER;
				hdr_cnt = 0;
			end else begin
				ph = PH_DIST0;
			end
		endfunction

		// Copy up to one burst from history, overlapping allowed.
		function void copy_burst();
			int n;
			n = 0;
			bursts++;
			while (match_left > 0 && n < BURST && n < MAX_RESULTS) begin
				emit(hist[wptr - back_dist]);
				match_left--;
				n++;
			end
			if (match_left == 0) begin
				ph = (budget == 0) ? PH_HEADER : PH_TOKEN;
				hdr_cnt = 0;
			end
		endfunction

		// Advance the mirror by one accepted input beat.
		function void note_beat(logic c, logic [7:0] b);
			logic take;
			int cnt;
			result_t r;
			step_bytes.delete();
			take = !c && ph != PH_COPY && ph != PH_HALT &&
				!(ph == PH_HEADER && hdr_cnt == 0 && consumed >= stream_len);
			if (ph == PH_COPY) begin
				copy_burst();
			end else if (take) begin
				consumed = clamp_inc(consumed, 1);
				if (ph != PH_HEADER && budget > 0)
					budget--;
				case (ph)
					PH_HEADER: begin
						if (hdr_cnt == 0) begin
							budget = 0;
							produced = 0;
						end
						budget |= {24'd0, b} << (8 * hdr_cnt);
						hdr_cnt = hdr_cnt + 2'd1;
						if (hdr_cnt == 0)
							ph = (budget == 0) ? PH_HEADER : PH_TOKEN;
					end
					PH_TOKEN: begin
						mnib = b[3:0];
						lit_left = {28'd0, b[7:4]};
						if (b[7:4] == NIBBLE_EXT)
							ph = PH_LITEXT;
						else if (lit_left == 0)
							end_literals();
						else
							ph = PH_LIT;
					end
					PH_LITEXT: begin
						lit_left = clamp_inc(lit_left, {24'd0, b});
						if (b != BYTE_EXT) begin
							if (lit_left == 0)
								end_literals();
							else
								ph = PH_LIT;
						end
					end
					PH_LIT: begin
						emit(b);
						if (lit_left > 0)
							lit_left--;
						if (lit_left == 0)
							end_literals();
					end
					PH_DIST0: begin
						back_dist = {8'd0, b};
						ph = PH_DIST1;
					end
					PH_DIST1: begin
						back_dist[15:8] = b;
						if (back_dist == 0 || {16'd0, back_dist} > produced) begin
							ph = PH_HALT;
						end else if (mnib == NIBBLE_EXT) begin
							match_left = {28'd0, NIBBLE_EXT};
							ph = PH_MATCHEXT;
						end else begin
							match_left = {28'd0, mnib} + MIN_MATCH;
							ph = PH_COPY;
							copy_burst();
						end
					end
					PH_MATCHEXT: begin
						match_left = clamp_inc(match_left, {24'd0, b});
						if (b != BYTE_EXT) begin
							match_left = clamp_inc(match_left, MIN_MATCH);
							ph = PH_COPY;
							copy_burst();
						end
					end
					default: ;
				endcase
			end
			cnt = (step_bytes.size() == 0) ? 1 : step_bytes.size();
			for (int k = 0; k < cnt; k++) begin
				r.out_byte     = (step_bytes.size() == 0) ? 8'd0 : step_bytes[k];
				r.has_byte     = (step_bytes.size() != 0);
				r.error_flag   = (ph == PH_HALT);
				r.copy_pending = (ph == PH_COPY);
				r.stream_done  = (ph == PH_HEADER && hdr_cnt == 0 && consumed >= stream_len);
				r.last         = (k == cnt - 1);
				expected_q.push_back(r);
			end
		endfunction

		function void fail_note(string what, result_t e, result_t g);
			mismatches++;
			if (mismatches <= 10) begin
				$display("MISMATCH %s: exp byte=%h hb=%b err=%b pend=%b done=%b last=%b",
					what, e.out_byte, e.has_byte, e.error_flag, e.copy_pending,
					e.stream_done, e.last);
				$display("  got byte=%h hb=%b err=%b pend=%b done=%b last=%b",
					g.out_byte, g.has_byte, g.error_flag, g.copy_pending,
					g.stream_done, g.last);
			end
		endfunction

		function void check_result(result_t got);
			result_t e;
			results_seen++;
			if (got.has_byte === 1'b1)
				bytes_seen++;
			if (expected_q.size() == 0) begin
				fail_note("unexpected beat", '0, got);
				return;
			end
			e = expected_q.pop_front();
			if (got.out_byte !== e.out_byte || got.has_byte !== e.has_byte ||
					got.error_flag !== e.error_flag || got.copy_pending !== e.copy_pending ||
					got.stream_done !== e.stream_done || got.last !== e.last)
				fail_note("field", e, got);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [31:0] cfg_wdata;

	lz4h_in_if  din_if();
	lz4h_out_if dout_if();

	lz4_style_hunk_decompressor #(.HISTORY_DEPTH(65536), .BURST(BURST)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.din       (din_if),
		.dout      (dout_if)
	);

	hunk_scoreboard sb;
	bit quiet;         // no idling on either side while set
	int stall_left;
	int beats_sent;
	int hunks_sent;

	always #5 clk = ~clk;

	// Result side: random stall bursts unless quiet.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			dout_if.ready <= 1'b0;
		end else if (!quiet && arst_n && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 6);
			dout_if.ready <= 1'b0;
		end else begin
			dout_if.ready <= 1'b1;
		end
	end

	// Sample at the falling edge: a beat seen here is taken at the next rising edge.
	always @(negedge clk) begin
		if (arst_n && dout_if.valid === 1'b1 && dout_if.ready === 1'b1)
			sb.check_result({dout_if.out_byte, dout_if.has_byte, dout_if.error_flag,
				dout_if.copy_pending, dout_if.stream_done, dout_if.last});
	end

	// Offer one beat; return at the rising edge that takes it.
	task automatic send_beat(logic c, logic [7:0] b);
		int gap;
		gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
		if (gap > 0) begin
			din_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		din_if.valid <= 1'b1;
		din_if.cmd <= c;
		din_if.in_byte <= b;
		do @(negedge clk); while (din_if.ready !== 1'b1);
		@(posedge clk);
		sb.note_beat(c, b);
		beats_sent++;
	endtask

	// Send a stream byte, then drain any copy it started. Some drains are
	// plain bytes offered mid-copy, which the block must not consume.
	task automatic send_byte(logic [7:0] b);
		send_beat(1'b0, b);
		while (sb.ph == PH_COPY)
			send_beat($urandom_range(0, 3) != 0, 8'($urandom_range(0, 255)));
		if ($urandom_range(0, 15) == 0)
			send_beat(1'b1, 8'($urandom_range(0, 255)));
	endtask

	// Hold the input idle until every expected beat is back.
	task automatic wait_idle();
		din_if.valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_length(logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.stream_len = v;
	endtask

	task automatic push_ext(ref logic [7:0] q[$], input int rem);
		while (rem >= 255) begin
			q.push_back(BYTE_EXT);
			rem -= 255;
		end
		q.push_back(rem[7:0]);
	endtask

	// Build one well-formed hunk, header included, with random content.
	task automatic build_hunk(ref logic [7:0] q[$]);
		logic [7:0] body[$];
		int prod, nseq, lits, mlen, d, lnib, mn, sel;
		logic want_match;
		prod = 0;
		nseq = $urandom_range(1, 4);
		for (int i = 0; i < nseq; i++) begin
			want_match = (i != nseq - 1) || $urandom_range(0, 1);
			sel = $urandom_range(0, 11);
			if (prod == 0)
				lits = $urandom_range(1, 8);
			else if (sel == 0)
				lits = 0;
			else if (sel == 1)
				lits = 15 + (($urandom_range(0, 3) == 0) ? $urandom_range(240, 300)
					: $urandom_range(0, 20));
			else
				lits = $urandom_range(1, 14);
			sel = $urandom_range(0, 9);
			if (sel == 0)
				mlen = 19 + (($urandom_range(0, 2) == 0) ? $urandom_range(250, 300)
					: $urandom_range(0, 40));
			else
				mlen = $urandom_range(4, 18);
			lnib = (lits >= 15) ? 15 : lits;
			mn = !want_match ? $urandom_range(0, 15) : ((mlen - 4 >= 15) ? 15 : mlen - 4);
			body.push_back({lnib[3:0], mn[3:0]});
			if (lits >= 15)
				push_ext(body, lits - 15);
			repeat (lits) body.push_back(8'($urandom_range(0, 255)));
			prod += lits;
			if (want_match) begin
				d = $urandom_range(0, 1) ? $urandom_range(1, (prod > 3) ? 3 : prod)
					: $urandom_range(1, (prod > 65535) ? 65535 : prod);
				body.push_back(d[7:0]);
				body.push_back(d[15:8]);
				if (mn == 15)
					push_ext(body, mlen - 19);
				prod += mlen;
			end
		end
		for (int k = 0; k < 4; k++)
			q.push_back(8'(body.size() >> (8 * k)));
		foreach (body[k])
			q.push_back(body[k]);
	endtask

	initial begin
		logic [7:0] stream[$];
		logic [31:0] bad;
		int nh;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		din_if.valid = 1'b0;
		din_if.cmd = 1'b0;
		din_if.in_byte = '0;
		dout_if.ready = 1'b0;
		stall_left = 0;
		quiet = 1'b0;
		beats_sent = 0;
		hunks_sent = 0;
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero length: every byte is ignored, drains only report status.
		write_length(32'd0);
		send_beat(1'b0, 8'h00);
		send_beat(1'b0, 8'hff);
		send_beat(1'b1, 8'h5a);
		wait_idle();

		// Directed: zero-budget hunk, literals 00/ff with an overlapping
		// copy at distance one, then a hunk whose literals overrun its budget.
		stream = '{8'h00, 8'h00, 8'h00, 8'h00,
			8'h07, 8'h00, 8'h00, 8'h00, 8'h20, 8'h00, 8'hff, 8'h01, 8'h00,
			8'h10, 8'h80,
			8'h01, 8'h00, 8'h00, 8'h00, 8'h30, 8'h11, 8'h22, 8'h33};
		write_length(sb.consumed + stream.size());
		foreach (stream[k])
			send_byte(stream[k]);
		send_byte(8'h42);   // past the end of the stream: ignored
		wait_idle();

		// Random streams of one to three hunks, one length setting each.
		while (beats_sent < 280) begin
			quiet = ($urandom_range(0, 3) == 0);
			stream.delete();
			nh = $urandom_range(1, 3);
			repeat (nh) build_hunk(stream);
			hunks_sent += nh;
			write_length(sb.consumed + stream.size());
			foreach (stream[k])
				send_byte(stream[k]);
			repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)));
			wait_idle();
		end

		// Last part, no idling: unbounded length, one more hunk, then a bad distance.
		quiet = 1'b1;
		write_length(32'hffff_ffff);
		stream.delete();
		build_hunk(stream);
		hunks_sent++;
		bad = $urandom_range(0, 1) ? 32'd0 : 32'd2;
		stream.push_back(8'h05);
		stream.push_back(8'h00);
		stream.push_back(8'h00);
		stream.push_back(8'h00);
		stream.push_back(8'h10);
		stream.push_back(8'($urandom_range(0, 255)));
		stream.push_back(bad[7:0]);
		stream.push_back(bad[15:8]);
		foreach (stream[k])
			send_byte(stream[k]);
		send_beat(1'b0, 8'h00);
		send_beat(1'b1, 8'hff);
		send_beat(1'b0, 8'h3c);

		wait_idle();
		repeat (30) @(posedge clk);
		if (sb.expected_q.size() != 0) begin
			sb.mismatches++;
			$display("%0d expected result beats never arrived", sb.expected_q.size());
		end
		$display("Sent %0d input beats over %0d random hunks; %0d result beats, %0d bytes out.",
			beats_sent, hunks_sent, sb.results_seen, sb.bytes_seen);
		$display("Match bursts: %0d; mismatches: %0d.", sb.bursts, sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("lz4_style_hunk_decompressor verification clean");
		end else begin
			$display("lz4_style_hunk_decompressor verification failed");
		end
		$finish;
	end

	// Hard stop far beyond the slowest legal run.
	initial begin
		#15_000_000;
		$display("Timeout: run did not finish");
		$display("lz4_style_hunk_decompressor verification failed");
		$finish;
	end

endmodule

### lz4_style_hunk_decompressor.f
+incdir+rtl
rtl/lz4h_pkg.sv
rtl/lz4h_if.sv
rtl/lz4h_ram.sv
rtl/lz4h_ctrl.sv
rtl/lz4h_dp.sv
rtl/lz4_style_hunk_decompressor.sv
rtl/lz4h_checker.sv
test/testbench.sv
